// ===== src/slcp_pkg.sv =====
// ----------------------------------------------------------------------------
// slcp_pkg
// Types and constants for the segment length constraint projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package slcp_pkg;

    // coordinate and register formats
    localparam int COORD_W = 32;
    localparam int CFG_W   = 31;
    localparam int ERR_W   = 32;

    // difference, square and square-root widths
    localparam int D_W        = COORD_W + 1;
    localparam int SQ_W       = 2 * D_W;
    localparam int RAD_W      = 2 * D_W + 2;
    localparam int LEN_W      = RAD_W / 2;
    localparam int SQ_STEPS   = LEN_W;
    localparam int SQ_REM_W   = LEN_W + 3;

    // error, product and divider widths
    localparam int AERR_W     = LEN_W;
    localparam int PROD_W     = D_W + AERR_W;
    localparam int Q_W        = LEN_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int DIV_REM_W  = LEN_W + 1;
    localparam int SH_W       = Q_W + 2;

    // register layers from request to result
    localparam int LATENCY    = 4 + SQ_STEPS + 2 + DIV_STEPS + 1;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_TARGET    = 1'b0,
        CFG_TOLERANCE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      start_locked;
        logic                      end_locked;
    } t_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] new_start_x;
        logic signed [COORD_W-1:0] new_start_y;
        logic signed [COORD_W-1:0] new_end_x;
        logic signed [COORD_W-1:0] new_end_y;
        logic        [ERR_W-1:0]   length_error;
        logic                      satisfied;
        logic                      moved;
    } t_res;

    // request plus its endpoint differences
    typedef struct packed {
        t_req                  req;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
    } t_geom;

    // per-request results of the error stage
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [AERR_W-1:0] aerr;
        logic              err_neg;
        logic              satisfied;
        logic              moved;
        logic              two_free;
        logic              len_zero;
    } t_meta;

endpackage

`default_nettype wire

// ===== src/segment_length_constraint_projection.sv =====
// ----------------------------------------------------------------------------
// segment_length_constraint_projection
// Moves the free endpoints of a segment so its length approaches a target.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which i_start is high and o_busy is
// low; o_busy is high only during reset and the cycle after it. Each request
// gives one result, shown for one cycle with o_res_valid; the receiver cannot
// stall. Most stages belong to the pipelined square root (one root bit per
// stage, 34 stages) and the two pipelined dividers (one quotient bit per
// stage, 34 stages). Write target_length and tolerance only while no request
// is in flight.
`default_nettype none

module segment_length_constraint_projection
    import slcp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire t_req             i_req,
    output logic                  o_res_valid,
    output t_res                  o_res,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    logic             r_busy;
    logic [CFG_W-1:0] r_target;
    logic [CFG_W-1:0] r_tol;

    // busy only around reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy      = r_busy;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_tol    <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET:    r_target <= i_cfg_data;
                CFG_TOLERANCE: r_tol    <= i_cfg_data;
                default:       r_target <= r_target;
            endcase
        end
    end

    // stage 0: request capture
    logic r_s0_valid;
    t_req r_s0_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_start && !r_busy;
        end
        r_s0_req <= i_req;
    end

    // stage 1: endpoint differences
    logic  r_s1_valid;
    t_geom r_s1_geom;
    logic signed [D_W-1:0] n_dx;
    logic signed [D_W-1:0] n_dy;

    assign n_dx = {r_s0_req.end_x[COORD_W-1], r_s0_req.end_x}
                - {r_s0_req.start_x[COORD_W-1], r_s0_req.start_x};
    assign n_dy = {r_s0_req.end_y[COORD_W-1], r_s0_req.end_y}
                - {r_s0_req.start_y[COORD_W-1], r_s0_req.start_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_s0_valid;
        end
        r_s1_geom.req <= r_s0_req;
        r_s1_geom.dx  <= n_dx;
        r_s1_geom.dy  <= n_dy;
    end

    // stage 2: squares of the magnitudes
    logic [D_W-1:0]  n_ux;
    logic [D_W-1:0]  n_uy;
    logic            r_s2_valid;
    t_geom           r_s2_geom;
    logic [SQ_W-1:0] r_sqx;
    logic [SQ_W-1:0] r_sqy;

    assign n_ux = r_s1_geom.dx[D_W-1] ? D_W'(-r_s1_geom.dx) : D_W'(r_s1_geom.dx);
    assign n_uy = r_s1_geom.dy[D_W-1] ? D_W'(-r_s1_geom.dy) : D_W'(r_s1_geom.dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_geom <= r_s1_geom;
        r_sqx     <= SQ_W'(n_ux) * SQ_W'(n_ux);
        r_sqy     <= SQ_W'(n_uy) * SQ_W'(n_uy);
    end

    // square root pipeline, entry 0 holds the radicand
    logic                r_sq_valid [0:SQ_STEPS];
    t_geom               r_sq_geom  [0:SQ_STEPS];
    logic [RAD_W-1:0]    r_sq_rad   [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] r_sq_rem   [0:SQ_STEPS];
    logic [LEN_W-1:0]    r_sq_root  [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else begin
            r_sq_valid[0] <= r_s2_valid;
        end
        r_sq_geom[0] <= r_s2_geom;
        r_sq_rad[0]  <= RAD_W'(r_sqx) + RAD_W'(r_sqy);
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [SQ_REM_W-1:0] n_rem_sh;
        logic [SQ_REM_W-1:0] n_trial;
        logic                n_ge;

        // bring down two radicand bits, try root bit one
        assign n_rem_sh = {r_sq_rem[k][SQ_REM_W-3:0], r_sq_rad[k][RAD_W-1 -: 2]};
        assign n_trial  = {1'b0, r_sq_root[k], 2'b01};
        assign n_ge     = n_rem_sh >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k+1] <= 1'b0;
            end else begin
                r_sq_valid[k+1] <= r_sq_valid[k];
            end
            r_sq_geom[k+1] <= r_sq_geom[k];
            r_sq_rad[k+1]  <= {r_sq_rad[k][RAD_W-3:0], 2'b00};
            r_sq_rem[k+1]  <= n_ge ? n_rem_sh - n_trial : n_rem_sh;
            r_sq_root[k+1] <= {r_sq_root[k][LEN_W-2:0], n_ge};
        end
    end

    // error stage: signed error, flags
    logic signed [LEN_W:0] n_err;
    logic [AERR_W-1:0]     n_aerr;
    logic                  n_two_free;
    logic                  n_any_free;
    logic                  r_e_valid;
    t_geom                 r_e_geom;
    t_meta                 r_e_meta;

    assign n_err = $signed({1'b0, r_sq_root[SQ_STEPS]})
                 - $signed({{(LEN_W+1-CFG_W){1'b0}}, r_target});
    assign n_aerr     = n_err[LEN_W] ? AERR_W'(-n_err) : AERR_W'(n_err);
    assign n_two_free = !r_sq_geom[SQ_STEPS].req.start_locked
                     && !r_sq_geom[SQ_STEPS].req.end_locked;
    assign n_any_free = !r_sq_geom[SQ_STEPS].req.start_locked
                     || !r_sq_geom[SQ_STEPS].req.end_locked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_sq_valid[SQ_STEPS];
        end
        r_e_geom           <= r_sq_geom[SQ_STEPS];
        r_e_meta.len       <= r_sq_root[SQ_STEPS];
        r_e_meta.aerr      <= n_aerr;
        r_e_meta.err_neg   <= n_err[LEN_W];
        r_e_meta.satisfied <= n_aerr < AERR_W'(r_tol);
        r_e_meta.moved     <= (n_aerr != '0) && n_any_free;
        r_e_meta.two_free  <= n_two_free;
        r_e_meta.len_zero  <= r_sq_root[SQ_STEPS] == '0;
    end

    // product stage feeds the dividers, entry 0 holds the upper dividend
    logic [D_W-1:0]       n_ax;
    logic [D_W-1:0]       n_ay;
    logic [PROD_W-1:0]    n_px;
    logic [PROD_W-1:0]    n_py;
    logic                 r_dv_valid [0:DIV_STEPS];
    t_geom                r_dv_geom  [0:DIV_STEPS];
    t_meta                r_dv_meta  [0:DIV_STEPS];
    logic [Q_W-1:0]       r_dv_numx  [0:DIV_STEPS];
    logic [Q_W-1:0]       r_dv_numy  [0:DIV_STEPS];
    logic [DIV_REM_W-1:0] r_dv_remx  [0:DIV_STEPS];
    logic [DIV_REM_W-1:0] r_dv_remy  [0:DIV_STEPS];
    logic [Q_W-1:0]       r_dv_qx    [0:DIV_STEPS];
    logic [Q_W-1:0]       r_dv_qy    [0:DIV_STEPS];

    assign n_ax = r_e_geom.dx[D_W-1] ? D_W'(-r_e_geom.dx) : D_W'(r_e_geom.dx);
    assign n_ay = r_e_geom.dy[D_W-1] ? D_W'(-r_e_geom.dy) : D_W'(r_e_geom.dy);
    assign n_px = PROD_W'(n_ax) * PROD_W'(r_e_meta.aerr);
    assign n_py = PROD_W'(n_ay) * PROD_W'(r_e_meta.aerr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else begin
            r_dv_valid[0] <= r_e_valid;
        end
        r_dv_geom[0] <= r_e_geom;
        r_dv_meta[0] <= r_e_meta;
        r_dv_numx[0] <= n_px[Q_W-1:0];
        r_dv_numy[0] <= n_py[Q_W-1:0];
        r_dv_remx[0] <= DIV_REM_W'(n_px[PROD_W-1:Q_W]);
        r_dv_remy[0] <= DIV_REM_W'(n_py[PROD_W-1:Q_W]);
        r_dv_qx[0]   <= '0;
        r_dv_qy[0]   <= '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [DIV_REM_W-1:0] n_shx;
        logic [DIV_REM_W-1:0] n_shy;
        logic [DIV_REM_W-1:0] n_den;
        logic                 n_gex;
        logic                 n_gey;

        // restoring step, one quotient bit per axis
        assign n_den = {1'b0, r_dv_meta[k].len};
        assign n_shx = {r_dv_remx[k][DIV_REM_W-2:0], r_dv_numx[k][Q_W-1]};
        assign n_shy = {r_dv_remy[k][DIV_REM_W-2:0], r_dv_numy[k][Q_W-1]};
        assign n_gex = n_shx >= n_den;
        assign n_gey = n_shy >= n_den;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
            r_dv_geom[k+1] <= r_dv_geom[k];
            r_dv_meta[k+1] <= r_dv_meta[k];
            r_dv_numx[k+1] <= {r_dv_numx[k][Q_W-2:0], 1'b0};
            r_dv_numy[k+1] <= {r_dv_numy[k][Q_W-2:0], 1'b0};
            r_dv_remx[k+1] <= n_gex ? n_shx - n_den : n_shx;
            r_dv_remy[k+1] <= n_gey ? n_shy - n_den : n_shy;
            r_dv_qx[k+1]   <= {r_dv_qx[k][Q_W-2:0], n_gex};
            r_dv_qy[k+1]   <= {r_dv_qy[k][Q_W-2:0], n_gey};
        end
    end

    // final stage: shift sign and size, apply, saturate
    t_geom             n_fg;
    t_meta             n_fm;
    logic [Q_W-1:0]    n_magx;
    logic [Q_W-1:0]    n_magy;
    logic              n_negx;
    logic              n_negy;
    logic signed [SH_W-1:0] n_shiftx;
    logic signed [SH_W-1:0] n_shifty;
    logic signed [SH_W-1:0] n_sx;
    logic signed [SH_W-1:0] n_sy;
    logic signed [SH_W-1:0] n_ex;
    logic signed [SH_W-1:0] n_ey;
    t_res              n_res;
    logic              r_out_valid;
    t_res              r_out;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SH_W-1:0] v
    );
        logic signed [SH_W-1:0] hi;
        logic signed [SH_W-1:0] lo;
        hi = SH_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            sat_coord = hi[COORD_W-1:0];
        end else if (v < lo) begin
            sat_coord = lo[COORD_W-1:0];
        end else begin
            sat_coord = v[COORD_W-1:0];
        end
    endfunction

    function automatic logic signed [SH_W-1:0] ext_coord(
        input logic signed [COORD_W-1:0] c
    );
        ext_coord = {{(SH_W-COORD_W){c[COORD_W-1]}}, c};
    endfunction

    assign n_fg = r_dv_geom[DIV_STEPS];
    assign n_fm = r_dv_meta[DIV_STEPS];

    // zero length falls back to direction (1,0)
    always_comb begin
        if (n_fm.len_zero) begin
            n_magx = Q_W'(n_fm.aerr >> n_fm.two_free);
            n_magy = '0;
            n_negx = n_fm.err_neg;
            n_negy = 1'b0;
        end else begin
            n_magx = r_dv_qx[DIV_STEPS] >> n_fm.two_free;
            n_magy = r_dv_qy[DIV_STEPS] >> n_fm.two_free;
            n_negx = n_fg.dx[D_W-1] != n_fm.err_neg;
            n_negy = n_fg.dy[D_W-1] != n_fm.err_neg;
        end
        if (!n_fm.moved) begin
            n_magx = '0;
            n_magy = '0;
        end
    end

    assign n_shiftx = n_negx ? -$signed({2'b00, n_magx}) : $signed({2'b00, n_magx});
    assign n_shifty = n_negy ? -$signed({2'b00, n_magy}) : $signed({2'b00, n_magy});
    assign n_sx = ext_coord(n_fg.req.start_x) + n_shiftx;
    assign n_sy = ext_coord(n_fg.req.start_y) + n_shifty;
    assign n_ex = ext_coord(n_fg.req.end_x) - n_shiftx;
    assign n_ey = ext_coord(n_fg.req.end_y) - n_shifty;

    always_comb begin
        n_res.new_start_x  = n_fg.req.start_locked ? n_fg.req.start_x : sat_coord(n_sx);
        n_res.new_start_y  = n_fg.req.start_locked ? n_fg.req.start_y : sat_coord(n_sy);
        n_res.new_end_x    = n_fg.req.end_locked ? n_fg.req.end_x : sat_coord(n_ex);
        n_res.new_end_y    = n_fg.req.end_locked ? n_fg.req.end_y : sat_coord(n_ey);
        n_res.length_error = (n_fm.aerr > AERR_W'({ERR_W{1'b1}}))
                           ? {ERR_W{1'b1}} : n_fm.aerr[ERR_W-1:0];
        n_res.satisfied    = n_fm.satisfied;
        n_res.moved        = n_fm.moved;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_dv_valid[DIV_STEPS];
        end
        r_out <= n_res;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ===== src/slcp_checker.sv =====
// ----------------------------------------------------------------------------
// slcp_checker
// Port-level checks for the segment length constraint projection block.
// ----------------------------------------------------------------------------
`default_nettype none

module slcp_checker
    import slcp_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire t_req i_req,
    input wire logic o_res_valid,
    input wire t_res o_res
);

    // every accepted request yields a result after the fixed latency
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_res_valid)
        else $error("accepted request produced no result");

    // no result without a request the fixed latency earlier
    a_res_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without matching request");

    // a locked start point passes through unchanged
    a_start_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && $past(i_req.start_locked, LATENCY))
        |-> (o_res.new_start_x == $past(i_req.start_x, LATENCY))
         && (o_res.new_start_y == $past(i_req.start_y, LATENCY)))
        else $error("locked start point moved");

    // no correction means the end point and start x come back as given
    a_unmoved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.moved)
        |-> (o_res.new_end_x == $past(i_req.end_x, LATENCY))
         && (o_res.new_end_y == $past(i_req.end_y, LATENCY))
         && (o_res.new_start_x == $past(i_req.start_x, LATENCY)))
        else $error("endpoints changed without correction");

    // a satisfied result has an error below any 31-bit tolerance
    a_satisfied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.satisfied) |-> !o_res.length_error[ERR_W-1])
        else $error("satisfied with out-of-range error");

endmodule

bind segment_length_constraint_projection slcp_checker u_slcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_req       (i_req),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

`default_nettype wire

// ===== tb/segment_length_constraint_projection_tb.sv =====
// ----------------------------------------------------------------------------
// segment_length_constraint_projection_tb
// Drives segments through the projection block and checks every result against
// a bit-exact predictor or typed rows, over several target/tolerance settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module segment_length_constraint_projection_tb;
    import slcp_pkg::*;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam int     N_DIRECTED = 14;
    localparam int     N_RESET_ROWS = 3;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    t_req             i_req;
    logic             o_res_valid;
    t_res             o_res;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [0:0]       i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    // predictor copy of the registers
    logic [CFG_W-1:0] target_len;
    logic [CFG_W-1:0] tol;

    t_res projected_q[$];
    bit   mismatch_seen;

    // one directed row: request and, where obvious, its result
    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    t_row rows[N_DIRECTED];

    segment_length_constraint_projection u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint saturate(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // exact d * err / (len * nfree), truncated toward zero
    function automatic longint axis_shift(longint d, longint err, longint len, int nfree);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        longint       s;
        num = 128'(mag(d)) * 128'(mag(err));
        den = 128'(len) * 128'(nfree);
        q = num / den;
        s = longint'(q[63:0]);
        return ((d < 0) != (err < 0)) ? -s : s;
    endfunction

    function automatic t_res project_segment(t_req r);
        longint       sx, sy, ex, ey, dx, dy, len, err, aerr, shx, shy;
        logic [65:0]  sumsq;
        logic [67:0]  cand;
        logic [33:0]  root;
        int           nfree;
        bit           moved;
        t_res         o;
        sx = longint'($signed(r.start_x));
        sy = longint'($signed(r.start_y));
        ex = longint'($signed(r.end_x));
        ey = longint'($signed(r.end_y));
        dx = ex - sx;
        dy = ey - sy;
        sumsq = 66'(mag(dx)) * 66'(mag(dx)) + 66'(mag(dy)) * 66'(mag(dy));
        root = '0;
        for (int i = 33; i >= 0; i--) begin
            cand = 68'(root | (34'd1 << i));
            if (cand * cand <= 68'(sumsq)) root = cand[33:0];
        end
        len = longint'(root);
        err = len - longint'(target_len);
        aerr = mag(err);
        nfree = (r.start_locked ? 0 : 1) + (r.end_locked ? 0 : 1);
        moved = (err != 0) && (nfree > 0);
        if (moved) begin
            if (len == 0) begin
                shx = err / nfree;
                shy = 0;
            end else begin
                shx = axis_shift(dx, err, len, nfree);
                shy = axis_shift(dy, err, len, nfree);
            end
            if (!r.start_locked) begin
                sx = saturate(sx + shx);
                sy = saturate(sy + shy);
            end
            if (!r.end_locked) begin
                ex = saturate(ex - shx);
                ey = saturate(ey - shy);
            end
        end
        o.new_start_x = sx[31:0];
        o.new_start_y = sy[31:0];
        o.new_end_x = ex[31:0];
        o.new_end_y = ey[31:0];
        o.length_error = (aerr > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : aerr[31:0];
        o.satisfied = (aerr < longint'(tol));
        o.moved = moved;
        return o;
    endfunction

    function automatic t_req make_req(longint sx, longint sy, longint ex, longint ey,
                                      bit sl, bit el);
        t_req r;
        r.start_x = sx[31:0];
        r.start_y = sy[31:0];
        r.end_x = ex[31:0];
        r.end_y = ey[31:0];
        r.start_locked = sl;
        r.end_locked = el;
        return r;
    endfunction

    function automatic t_res make_res(longint sx, longint sy, longint ex, longint ey,
                                      logic [31:0] lerr, bit sat, bit mv);
        t_res o;
        o.new_start_x = sx[31:0];
        o.new_start_y = sy[31:0];
        o.new_end_x = ex[31:0];
        o.new_end_y = ey[31:0];
        o.length_error = lerr;
        o.satisfied = sat;
        o.moved = mv;
        return o;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatch_seen = 1;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_res_valid) begin
            if (projected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_res);
                mismatch_seen = 1;
            end else begin
                e = projected_q.pop_front();
                check_field("new_start_x", e.new_start_x, o_res.new_start_x);
                check_field("new_start_y", e.new_start_y, o_res.new_start_y);
                check_field("new_end_x", e.new_end_x, o_res.new_end_x);
                check_field("new_end_y", e.new_end_y, o_res.new_end_y);
                check_field("length_error", e.length_error, o_res.length_error);
                check_field("satisfied", e.satisfied, o_res.satisfied);
                check_field("moved", e.moved, o_res.moved);
            end
        end
    end

    // one request: optional idle gap, then hold start until taken
    task automatic send_request(t_req r, bit typed, t_res typed_res);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_busy);
        projected_q.push_back(typed ? typed_res : project_segment(r));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TARGET) target_len = data;
        else tol = data;
    endtask

    // drain every outstanding request
    task automatic wait_idle();
        i_start <= 1'b0;
        while (projected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic longint rand_coord(int mode);
        longint v;
        case (mode)
            0: v = longint'($signed($urandom()));
            1: v = longint'($urandom_range(0, 2097152)) - 1048576;
            2: v = ($urandom_range(0, 1) == 1) ? COORD_MAX - $urandom_range(0, 1048576)
                                               : COORD_MIN + $urandom_range(0, 1048576);
            default: v = longint'($urandom_range(0, 64)) - 32;
        endcase
        return v;
    endfunction

    task automatic random_phase(int n_items);
        int     mode;
        longint sx, sy;
        t_req   r;
        for (int k = 0; k < n_items; k++) begin
            mode = $urandom_range(0, 3);
            sx = rand_coord(mode);
            sy = rand_coord(mode);
            case ($urandom_range(0, 7))
                0: r = make_req(sx, sy, sx, sy, $urandom_range(0, 1), $urandom_range(0, 1));
                1: r = make_req(sx, sy, sx + longint'(target_len), sy,
                                $urandom_range(0, 1), $urandom_range(0, 1));
                default: r = make_req(sx, sy, rand_coord(mode), rand_coord(mode),
                                      $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
            send_request(r, 1'b0, '0);
        end
    endtask

    // stimulus
    initial begin
        longint T;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TARGET;
        i_cfg_data = '0;
        target_len = '0;
        tol = 31'd1;
        mismatch_seen = 0;
        T = 64'sd655360;

        // under reset settings: zero segment, 3-4-5 triangle, full-range locked
        rows[0] = '{make_req(0, 0, 0, 0, 1, 1), 1, make_res(0, 0, 0, 0, 0, 1, 0)};
        rows[1] = '{make_req(0, 0, 3, 4, 0, 0), 1, make_res(1, 2, 2, 2, 5, 0, 1)};
        rows[2] = '{make_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1, 1), 1,
                    make_res(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                             32'hFFFF_FFFF, 0, 0)};
        // with a target of 10.0
        rows[3] = '{make_req(0, 0, T, 0, 0, 0), 1, make_res(0, 0, T, 0, 0, 1, 0)};
        rows[4] = '{make_req(0, 0, 0, 0, 0, 1), 0, '0};
        rows[5] = '{make_req(100, -7, 100, -7, 0, 0), 0, '0};
        rows[6] = '{make_req(5, 5, 5, 5, 1, 0), 0, '0};
        rows[7] = '{make_req(0, 0, 2 * T, T, 0, 0), 0, '0};
        rows[8] = '{make_req(1000, 2000, 1300, 2400, 0, 0), 0, '0};
        rows[9] = '{make_req(0, 0, -3 * T, 4 * T, 1, 0), 0, '0};
        rows[10] = '{make_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0), 0, '0};
        rows[11] = '{make_req(COORD_MAX, 0, COORD_MAX - 10, 0, 0, 0), 0, '0};
        rows[12] = '{make_req(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0, 1), 0, '0};
        rows[13] = '{make_req(-T, 0, 0, 0, 1, 1), 0, '0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_RESET_ROWS; k++) send_request(rows[k].req, rows[k].typed,
                                                          rows[k].res);
        wait_idle();
        write_reg(CFG_TARGET, 31'(T));
        write_reg(CFG_TOLERANCE, 31'd256);
        for (int k = N_RESET_ROWS; k < N_DIRECTED; k++) send_request(rows[k].req, rows[k].typed,
                                                                  rows[k].res);

        // random sweeps across register settings, extremes included
        random_phase(100);
        wait_idle();
        write_reg(CFG_TARGET, 31'h7FFF_FFFF);
        write_reg(CFG_TOLERANCE, 31'h7FFF_FFFF);
        random_phase(100);
        wait_idle();
        write_reg(CFG_TARGET, '0);
        write_reg(CFG_TOLERANCE, '0);
        random_phase(100);
        wait_idle();
        write_reg(CFG_TARGET, 31'($urandom_range(0, 32'h0100_0000)));
        write_reg(CFG_TOLERANCE, 31'($urandom()));
        random_phase(100);
        wait_idle();
        write_reg(CFG_TARGET, 31'($urandom()));
        write_reg(CFG_TOLERANCE, 31'($urandom_range(0, 4096)));
        random_phase(100);

        wait_idle();
        if (!mismatch_seen && projected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
